FILE: rtl/core/nttpm_pkg.sv
// ----------------------------------------------------------------------------
// nttpm_pkg
// shared types, constants and modular helpers of the ntt polynomial core
// ----------------------------------------------------------------------------
package nttpm_pkg;

   localparam int MAX_LOG2_SIZE = 6;
   localparam int COEFF_BITS    = 63;
   localparam int DEPTH         = 1 << MAX_LOG2_SIZE;
   localparam int IDX_W         = MAX_LOG2_SIZE;
   localparam int CNT_W         = MAX_LOG2_SIZE + 1;
   localparam int STEP_W        = $clog2(COEFF_BITS);

   typedef logic [COEFF_BITS-1:0] coeff_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [2:0]            log2_type;
   typedef logic [2:0]            csr_index_type;
   typedef logic [1:0]            func_type;

   // register indexes
   localparam csr_index_type CSR_MODULUS      = 3'd0;
   localparam csr_index_type CSR_LOG2_SIZE    = 3'd1;
   localparam csr_index_type CSR_OMEGA        = 3'd2;
   localparam csr_index_type CSR_OMEGA_INV    = 3'd3;
   localparam csr_index_type CSR_PSI          = 3'd4;
   localparam csr_index_type CSR_PSI_INV      = 3'd5;
   localparam csr_index_type CSR_SIZE_INVERSE = 3'd6;

   // operation codes
   localparam func_type FUNC_FORWARD  = 2'd0;
   localparam func_type FUNC_INVERSE  = 2'd1;
   localparam func_type FUNC_MULTIPLY = 2'd2;

   localparam coeff_type RST_MODULUS = coeff_type'(12289);
   localparam log2_type  RST_LOG2    = log2_type'(6);
   localparam coeff_type COEFF_ONE   = coeff_type'(1);

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_PHASE,
      ST_CONST,
      ST_CONST_DONE,
      ST_ROOT,
      ST_ROOT_SQ,
      ST_EL_RD,
      ST_EL_GO,
      ST_EL_WR,
      ST_EL_PW,
      ST_PERM_RD,
      ST_PERM_W1,
      ST_PERM_W2,
      ST_BF_RD,
      ST_BF_GO,
      ST_BF_WR1,
      ST_BF_WR2,
      ST_BF_W,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_WAIT,
      ST_MWAIT
   } state_type;

   typedef enum logic [3:0] {
      PH_RED_A,
      PH_RED_B,
      PH_TW_A,
      PH_TW_B,
      PH_FWD_A,
      PH_FWD_B,
      PH_POINT,
      PH_INV_A,
      PH_SCALE,
      PH_UNTW,
      PH_OUT
   } phase_type;

   typedef struct packed {
      logic      start;
      coeff_type a;
      coeff_type b;
   } mul_cmd_type;

   typedef struct packed {
      logic      done;
      coeff_type res;
   } mul_sts_type;

   function automatic coeff_type add_mod(coeff_type a, coeff_type b, coeff_type q);
      logic [COEFF_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= {1'b0, q}) ? coeff_type'(s - {1'b0, q}) : coeff_type'(s);
   endfunction

   function automatic coeff_type sub_mod(coeff_type a, coeff_type b, coeff_type q);
      return (a >= b) ? a - b : a + (q - b);
   endfunction

   // reverse the low bits of an index
   function automatic idx_type bit_rev(idx_type i, log2_type bits);
      idx_type r;
      for (int k = 0; k < IDX_W; k++) begin
         r[k] = i[IDX_W-1-k];
      end
      return r >> (MAX_LOG2_SIZE - int'(bits));
   endfunction

endpackage

FILE: rtl/core/nttpm_if.sv
// ----------------------------------------------------------------------------
// nttpm channels
// valid/ready word channels for coefficients in and results out
// ----------------------------------------------------------------------------
interface nttpm_req_if;
   import nttpm_pkg::*;
   logic      valid;
   logic      ready;
   func_type  func;
   coeff_type a_value;
   coeff_type b_value;
   modport source (output valid, output func, output a_value, output b_value, input ready);
   modport sink   (input valid, input func, input a_value, input b_value, output ready);
endinterface

interface nttpm_rsp_if;
   import nttpm_pkg::*;
   logic      valid;
   logic      ready;
   coeff_type value;
   logic      last;
   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

FILE: rtl/core/nttpm_mulmod.sv
// ----------------------------------------------------------------------------
// nttpm_mulmod
// bit-serial modular multiplier, one bit of b per cycle, a canonical
// ----------------------------------------------------------------------------
module nttpm_mulmod (
   input  logic                 clock,
   input  logic                 reset,
   input  nttpm_pkg::coeff_type q,
   input  nttpm_pkg::mul_cmd_type cmd,
   output nttpm_pkg::mul_sts_type sts
);
   import nttpm_pkg::*;

   coeff_type           a_ff, a_in;
   coeff_type           b_ff, b_in;
   coeff_type           r_ff, r_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [COEFF_BITS:0] qx, dbl, red1, sum;

   always_comb begin
      qx   = {1'b0, q};
      dbl  = {r_ff, 1'b0};
      red1 = (dbl >= qx) ? dbl - qx : dbl;
      sum  = red1 + (b_ff[COEFF_BITS-1] ? {1'b0, a_ff} : '0);
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         a_in    = cmd.a;
         b_in    = cmd.b;
         r_in    = '0;
         cnt_in  = STEP_W'(COEFF_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // double, then add a when the bit is set
         r_in   = (sum >= qx) ? coeff_type'(sum - qx) : coeff_type'(sum);
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done = done_ff;
   assign sts.res  = r_ff;

endmodule

FILE: rtl/core/ntt_polynomial_multiplier_core.sv
// ----------------------------------------------------------------------------
// ntt_polynomial_multiplier_core
// forward / inverse ntt and negacyclic product mod x^n+1 over a prime q
// ----------------------------------------------------------------------------
// usage
//  - req_ch takes one word per coefficient: func, a_value, b_value; func of
//    the first word of a block picks forward, inverse or negacyclic multiply
//  - after n = 2^log2_size words the block computes, then sends n words on
//    rsp_ch in natural order, last set on the final one
//  - csr_* writes the modulus, size and roots; write only while idle
// timing
//  - req_ch.ready is high only while loading, one word per cycle
//  - every modular multiply runs on one shared bit-serial unit
// reset clears the sequencer and restores register defaults; store
// contents stay unknown until loaded. a stalled rsp_ch holds the word
// in the output register and the sequencer waits on it
// ----------------------------------------------------------------------------
module ntt_polynomial_multiplier_core (
   input  logic                     clock,
   input  logic                     reset,
   nttpm_req_if.sink                req_ch,
   nttpm_rsp_if.source              rsp_ch,
   input  logic                     csr_we,
   input  nttpm_pkg::csr_index_type csr_index,
   input  nttpm_pkg::coeff_type     csr_wdata
);
   import nttpm_pkg::*;

   // configuration registers
   coeff_type modulus_ff, omega_ff, omega_inv_ff, psi_ff, psi_inv_ff, size_inv_ff;
   log2_type  log2_size_ff;

   // sequencer
   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   phase_type phase_ff, phase_in;
   func_type  mode_ff, mode_in;
   cnt_type   lc_ff, lc_in;
   idx_type   i_ff, i_in;
   idx_type   j_ff, j_in;
   cnt_type   k_ff, k_in;
   log2_type  s_ff, s_in;

   // datapath registers
   coeff_type u_ff, u_in;
   coeff_type pw_ff, pw_in;
   coeff_type cst_ff, cst_in;
   coeff_type rcur_ff, rcur_in;
   coeff_type roots_ff [MAX_LOG2_SIZE];
   logic      roots_we;
   log2_type  roots_idx;
   coeff_type roots_wd;

   // output register
   coeff_type rsp_value_ff, rsp_value_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // coefficient stores
   coeff_type mem_a [DEPTH];
   coeff_type mem_b [DEPTH];
   coeff_type rda_x_ff, rda_y_ff, rdb_x_ff, rdb_y_ff;
   idx_type   rd_x_addr, rd_y_addr, wr_addr;
   logic      we_a, we_b;
   coeff_type wd_a, wd_b;

   mul_cmd_type mul_cmd;
   mul_sts_type mul_sts;

   // derived values
   coeff_type q;
   log2_type  bits;
   cnt_type   n;
   logic      req_acc, rsp_acc, lc_done;
   logic      i_last, fwd_ph, bank_b, pw_ph, perm_swap;
   logic      k_wrap, j_last, s_last;
   idx_type   rev_i, x_addr, y_addr;
   cnt_type   half, m;
   coeff_type rd_x, rd_y, stage_root, const_reg;

   function automatic phase_type next_phase(phase_type ph, func_type md);
      case (ph)
         PH_RED_A: begin
            if (md == FUNC_MULTIPLY) return PH_RED_B;
            else if (md == FUNC_INVERSE) return PH_INV_A;
            else return PH_FWD_A;
         end
         PH_RED_B: return PH_TW_A;
         PH_TW_A:  return PH_TW_B;
         PH_TW_B:  return PH_FWD_A;
         PH_FWD_A: return (md == FUNC_MULTIPLY) ? PH_FWD_B : PH_OUT;
         PH_FWD_B: return PH_POINT;
         PH_POINT: return PH_INV_A;
         PH_INV_A: return PH_SCALE;
         PH_SCALE: return (md == FUNC_MULTIPLY) ? PH_UNTW : PH_OUT;
         default:  return PH_OUT;
      endcase
   endfunction

   // modulus below 2 acts as 2, size clamps to 1..max
   assign q    = (modulus_ff < coeff_type'(2)) ? coeff_type'(2) : modulus_ff;
   assign bits = (log2_size_ff == '0) ? log2_type'(1) :
                 (log2_size_ff > log2_type'(MAX_LOG2_SIZE)) ? log2_type'(MAX_LOG2_SIZE) :
                 log2_size_ff;
   assign n    = cnt_type'(1) << bits;

   assign req_acc = req_ch.valid && req_ch.ready;
   assign rsp_acc = rsp_ch.valid && rsp_ch.ready;
   assign lc_done = cnt_type'(lc_ff + 1'b1) >= n;

   assign i_last    = cnt_type'(i_ff) == n - 1'b1;
   assign fwd_ph    = (phase_ff == PH_FWD_A) || (phase_ff == PH_FWD_B);
   assign bank_b    = (phase_ff == PH_RED_B) || (phase_ff == PH_TW_B) ||
                      (phase_ff == PH_FWD_B);
   assign pw_ph     = (phase_ff == PH_TW_A) || (phase_ff == PH_TW_B) ||
                      (phase_ff == PH_UNTW);
   assign rev_i     = bit_rev(i_ff, bits);
   assign perm_swap = i_ff < rev_i;

   // butterfly geometry: dit spans grow, dif spans shrink
   assign half   = fwd_ph ? (cnt_type'(1) << s_ff) : (n >> (s_ff + 1'b1));
   assign m      = half << 1;
   assign x_addr = idx_type'(cnt_type'(j_ff) + k_ff);
   assign y_addr = idx_type'(cnt_type'(x_addr) + half);
   assign k_wrap = (k_ff + m) >= n;
   assign j_last = cnt_type'(j_ff) == half - 1'b1;
   assign s_last = s_ff == bits - 1'b1;

   assign stage_root = fwd_ph ? roots_ff[s_ff] : roots_ff[log2_type'(bits - 1'b1 - s_ff)];
   assign rd_x       = bank_b ? rdb_x_ff : rda_x_ff;
   assign rd_y       = bank_b ? rdb_y_ff : rda_y_ff;

   always_comb begin
      case (phase_ff)
         PH_TW_A, PH_TW_B:   const_reg = psi_ff;
         PH_UNTW:            const_reg = psi_inv_ff;
         PH_FWD_A, PH_FWD_B: const_reg = omega_ff;
         PH_INV_A:           const_reg = omega_inv_ff;
         default:            const_reg = size_inv_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc && lc_done) state_in = ST_PHASE;
         end
         ST_PHASE: begin
            case (phase_ff)
               PH_RED_A, PH_RED_B, PH_POINT: state_in = ST_EL_RD;
               PH_OUT:                       state_in = ST_OUT_RD;
               default:                      state_in = ST_CONST;
            endcase
         end
         ST_CONST: begin
            state_in = ST_MWAIT;
            ret_in   = ST_CONST_DONE;
         end
         ST_CONST_DONE: begin
            state_in = (fwd_ph || phase_ff == PH_INV_A) ? ST_ROOT : ST_EL_RD;
         end
         ST_ROOT: begin
            if (s_ff == '0) begin
               state_in = fwd_ph ? ST_PERM_RD : ST_BF_RD;
            end else begin
               state_in = ST_MWAIT;
               ret_in   = ST_ROOT_SQ;
            end
         end
         ST_ROOT_SQ: state_in = ST_ROOT;
         ST_EL_RD:   state_in = ST_EL_GO;
         ST_EL_GO: begin
            state_in = ST_MWAIT;
            ret_in   = ST_EL_WR;
         end
         ST_EL_WR: begin
            if (pw_ph) begin
               state_in = ST_MWAIT;
               ret_in   = ST_EL_PW;
            end else begin
               state_in = i_last ? ST_PHASE : ST_EL_RD;
            end
         end
         ST_EL_PW: state_in = i_last ? ST_PHASE : ST_EL_RD;
         ST_PERM_RD: begin
            if (perm_swap) state_in = ST_PERM_W1;
            else if (i_last) state_in = fwd_ph ? ST_BF_RD : ST_PHASE;
         end
         ST_PERM_W1: state_in = ST_PERM_W2;
         ST_PERM_W2: begin
            if (i_last) state_in = fwd_ph ? ST_BF_RD : ST_PHASE;
            else state_in = ST_PERM_RD;
         end
         ST_BF_RD: state_in = ST_BF_GO;
         ST_BF_GO: begin
            state_in = ST_MWAIT;
            ret_in   = ST_BF_WR1;
         end
         ST_BF_WR1: state_in = ST_BF_WR2;
         ST_BF_WR2: begin
            if (k_wrap) begin
               if (j_last) begin
                  if (s_last) state_in = fwd_ph ? ST_PHASE : ST_PERM_RD;
                  else state_in = ST_BF_RD;
               end else begin
                  state_in = ST_MWAIT;
                  ret_in   = ST_BF_W;
               end
            end else begin
               state_in = ST_BF_RD;
            end
         end
         ST_BF_W:   state_in = ST_BF_RD;
         ST_OUT_RD: state_in = ST_OUT_LD;
         ST_OUT_LD: state_in = ST_OUT_WAIT;
         ST_OUT_WAIT: begin
            if (rsp_acc) state_in = rsp_last_ff ? ST_LOAD : ST_OUT_RD;
         end
         ST_MWAIT: begin
            if (mul_sts.done) state_in = ret_ff;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in      = mode_ff;
      lc_in        = lc_ff;
      phase_in     = phase_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      s_in         = s_ff;
      u_in         = u_ff;
      pw_in        = pw_ff;
      cst_in       = cst_ff;
      rcur_in      = rcur_ff;
      roots_we     = 1'b0;
      roots_idx    = s_ff;
      roots_wd     = mul_sts.res;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_x_addr    = i_ff;
      rd_y_addr    = i_ff;
      wr_addr      = i_ff;
      we_a         = 1'b0;
      we_b         = 1'b0;
      wd_a         = mul_sts.res;
      wd_b         = mul_sts.res;
      mul_cmd      = '{start: 1'b0, a: COEFF_ONE, b: pw_ff};

      case (state_ff)
         ST_LOAD: begin
            wr_addr = lc_ff[IDX_W-1:0];
            wd_a    = req_ch.a_value;
            wd_b    = req_ch.b_value;
            if (req_acc) begin
               we_a = 1'b1;
               we_b = 1'b1;
               if (lc_ff == '0) mode_in = req_ch.func;
               if (lc_done) begin
                  lc_in    = '0;
                  phase_in = PH_RED_A;
               end else begin
                  lc_in = lc_ff + 1'b1;
               end
            end
         end
         ST_PHASE: i_in = '0;
         ST_CONST: mul_cmd = '{start: 1'b1, a: COEFF_ONE, b: const_reg};
         ST_CONST_DONE: begin
            cst_in   = mul_sts.res;
            pw_in    = COEFF_ONE;
            // top stage root is the reduced register value itself
            rcur_in   = mul_sts.res;
            roots_we  = fwd_ph || (phase_ff == PH_INV_A);
            roots_idx = bits - 1'b1;
            s_in      = bits - 1'b1;
         end
         ST_ROOT: begin
            if (s_ff == '0) begin
               i_in  = '0;
               j_in  = '0;
               k_in  = '0;
               pw_in = COEFF_ONE;
            end else begin
               mul_cmd = '{start: 1'b1, a: rcur_ff, b: rcur_ff};
            end
         end
         ST_ROOT_SQ: begin
            roots_we  = 1'b1;
            roots_idx = s_ff - 1'b1;
            rcur_in   = mul_sts.res;
            s_in      = s_ff - 1'b1;
         end
         ST_EL_GO: begin
            mul_cmd.start = 1'b1;
            case (phase_ff)
               PH_RED_A, PH_RED_B: begin
                  mul_cmd.a = COEFF_ONE;
                  mul_cmd.b = rd_x;
               end
               PH_POINT: begin
                  mul_cmd.a = rda_x_ff;
                  mul_cmd.b = rdb_x_ff;
               end
               PH_SCALE: begin
                  mul_cmd.a = rd_x;
                  mul_cmd.b = cst_ff;
               end
               default: begin
                  mul_cmd.a = rd_x;
                  mul_cmd.b = pw_ff;
               end
            endcase
         end
         ST_EL_WR: begin
            we_a = !bank_b;
            we_b = bank_b;
            if (pw_ph) mul_cmd = '{start: 1'b1, a: pw_ff, b: cst_ff};
            else if (!i_last) i_in = i_ff + 1'b1;
         end
         ST_EL_PW: begin
            pw_in = mul_sts.res;
            if (!i_last) i_in = i_ff + 1'b1;
         end
         ST_PERM_RD: begin
            rd_y_addr = rev_i;
            if (!perm_swap) begin
               if (!i_last) begin
                  i_in = i_ff + 1'b1;
               end else begin
                  s_in  = '0;
                  j_in  = '0;
                  k_in  = '0;
                  pw_in = COEFF_ONE;
               end
            end
         end
         ST_PERM_W1: begin
            we_a = !bank_b;
            we_b = bank_b;
            wd_a = rd_y;
            wd_b = rd_y;
            u_in = rd_x;
         end
         ST_PERM_W2: begin
            wr_addr = rev_i;
            we_a    = !bank_b;
            we_b    = bank_b;
            wd_a    = u_ff;
            wd_b    = u_ff;
            if (!i_last) begin
               i_in = i_ff + 1'b1;
            end else begin
               s_in  = '0;
               j_in  = '0;
               k_in  = '0;
               pw_in = COEFF_ONE;
            end
         end
         ST_BF_RD: begin
            rd_x_addr = x_addr;
            rd_y_addr = y_addr;
         end
         ST_BF_GO: begin
            mul_cmd.start = 1'b1;
            mul_cmd.b     = pw_ff;
            if (fwd_ph) begin
               u_in      = rd_x;
               mul_cmd.a = rd_y;
            end else begin
               u_in      = add_mod(rd_x, rd_y, q);
               mul_cmd.a = sub_mod(rd_x, rd_y, q);
            end
         end
         ST_BF_WR1: begin
            wr_addr = x_addr;
            we_a    = !bank_b;
            we_b    = bank_b;
            wd_a    = fwd_ph ? add_mod(u_ff, mul_sts.res, q) : u_ff;
            wd_b    = wd_a;
         end
         ST_BF_WR2: begin
            wr_addr = y_addr;
            we_a    = !bank_b;
            we_b    = bank_b;
            wd_a    = fwd_ph ? sub_mod(u_ff, mul_sts.res, q) : mul_sts.res;
            wd_b    = wd_a;
            if (k_wrap) begin
               k_in = '0;
               if (j_last) begin
                  j_in  = '0;
                  pw_in = COEFF_ONE;
                  if (s_last) i_in = '0;
                  else s_in = s_ff + 1'b1;
               end else begin
                  j_in    = j_ff + 1'b1;
                  mul_cmd = '{start: 1'b1, a: pw_ff, b: stage_root};
               end
            end else begin
               k_in = k_ff + m;
            end
         end
         ST_BF_W: pw_in = mul_sts.res;
         ST_OUT_LD: begin
            rsp_value_in = rda_x_ff;
            rsp_last_in  = i_last;
            rsp_valid_in = 1'b1;
         end
         ST_OUT_WAIT: begin
            if (rsp_acc) begin
               rsp_valid_in = 1'b0;
               if (!i_last) i_in = i_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (state_in == ST_PHASE && state_ff != ST_LOAD) phase_in = next_phase(phase_ff, mode_ff);
   end

   nttpm_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .q     (q),
      .cmd   (mul_cmd),
      .sts   (mul_sts)
   );

   // stores: one write port, two registered read ports each
   always_ff @(posedge clock) begin
      if (we_a) mem_a[wr_addr] <= wd_a;
      if (we_b) mem_b[wr_addr] <= wd_b;
      rda_x_ff <= mem_a[rd_x_addr];
      rda_y_ff <= mem_a[rd_y_addr];
      rdb_x_ff <= mem_b[rd_x_addr];
      rdb_y_ff <= mem_b[rd_y_addr];
   end

   always_ff @(posedge clock) begin
      if (roots_we) roots_ff[roots_idx] <= roots_wd;
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= RST_MODULUS;
         log2_size_ff <= RST_LOG2;
         omega_ff     <= COEFF_ONE;
         omega_inv_ff <= COEFF_ONE;
         psi_ff       <= COEFF_ONE;
         psi_inv_ff   <= COEFF_ONE;
         size_inv_ff  <= COEFF_ONE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODULUS:      modulus_ff   <= csr_wdata;
            CSR_LOG2_SIZE:    log2_size_ff <= csr_wdata[2:0];
            CSR_OMEGA:        omega_ff     <= csr_wdata;
            CSR_OMEGA_INV:    omega_inv_ff <= csr_wdata;
            CSR_PSI:          psi_ff       <= csr_wdata;
            CSR_PSI_INV:      psi_inv_ff   <= csr_wdata;
            CSR_SIZE_INVERSE: size_inv_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // sequencer and datapath registers
   always_ff @(posedge clock) begin
      u_ff         <= u_in;
      pw_ff        <= pw_in;
      cst_ff       <= cst_in;
      rcur_ff      <= rcur_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      s_ff         <= s_in;
      ret_ff       <= ret_in;
      phase_ff     <= phase_in;
      if (reset) begin
         state_ff     <= ST_LOAD;
         lc_ff        <= '0;
         mode_ff      <= FUNC_FORWARD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lc_ff        <= lc_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ch.ready = (state_ff == ST_LOAD);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.value = rsp_value_ff;
   assign rsp_ch.last  = rsp_last_ff;

   // loading and sending never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("load and result phases overlap");

   // every word the datapath stores is canonical
   a_store_canon: assert property (@(posedge clock) disable iff (reset)
      ((we_a || we_b) && state_ff != ST_LOAD) |-> (wd_a < q))
      else $error("non-canonical word written to store");

   // results are canonical
   a_rsp_canon: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.value < q))
      else $error("result word not below modulus");

   // taking the final word reopens loading
   a_last_reload: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_ch.last) |=> req_ch.ready)
      else $error("block did not return to loading after last word");

endmodule
